/* hw/rtl/lmsq_pkg.sv */
package lmsq_pkg;

	// counter and register widths
	localparam int CNT_W     = 8;
	localparam int REP_W     = 8;
	localparam int ARC_W     = 19;
	localparam int DIST_W    = 20;
	localparam int SENS_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 19;
	localparam int NUM_MARKS = 10;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// register reset values
	localparam logic [REP_W-1:0] MARK_REPEAT_RST  = 8'd1;
	localparam logic [REP_W-1:0] WHITE_REPEAT_RST = 8'd2;
	localparam logic [ARC_W-1:0] TRIP_LEN_RST     = 19'd1920;

	// single runs of five or more adjacent set sensors
	localparam logic [SENS_W-1:0] MARK_PATTERNS [NUM_MARKS] = '{
		8'h1F, 8'h3E, 8'h7C, 8'hF8, 8'h3F, 8'h7E, 8'hFC, 8'h7F, 8'hFE, 8'hFF
	};

	typedef enum logic [1:0] {
		MODE_BLACK = 2'd0,
		MODE_WHITE = 2'd1,
		MODE_MARK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARK_REPEAT  = 2'd0,
		REG_WHITE_REPEAT = 2'd1,
		REG_TRIP_LEN     = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [SENS_W-1:0]        sensor_bits;
		logic signed [DIST_W-1:0] distance;
	} poll_t;

	typedef struct packed {
		logic             done_res;
		logic             mark_seen;
		logic [CNT_W-1:0] white_run;
		logic [CNT_W-1:0] mark_run;
	} result_t;

	// classified poll handed from front to back
	typedef struct packed {
		mode_t mode;
		logic  mark_seen;
		logic  any_set;
		logic  dist_ok;
	} cls_t;

	// settings seen by the back end
	typedef struct packed {
		logic [REP_W-1:0] mark_repeat;
		logic [REP_W-1:0] white_repeat;
	} rep_cfg_t;

	function automatic logic is_mark(input logic [SENS_W-1:0] bits);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_MARKS; i++) begin
			if (MARK_PATTERNS[i] == bits) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

/* hw/rtl/line_mark_stop_qualifier.sv */
// each poll is registered in the front stage, queued as a class, then queued as a result
// throughput: one poll per cycle unless a queue is full; counters update per class pop
// front stage, 2-entry class queue and 2-entry result queue let each side stall alone
// reset: queues empty, both run counters zero, mark_repeat 1, white_repeat 2,
// trip length 1920; configuration writes are always taken
module line_mark_stop_qualifier
	import lmsq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  poll_t                poll,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [REP_W-1:0] mark_repeat_q;
	logic [REP_W-1:0] white_repeat_q;
	logic [ARC_W-1:0] trip_len_q;
	rep_cfg_t         rep_cfg;
	logic             cq_push;
	logic             cq_full;
	logic             cq_pop;
	logic             cq_empty;
	cls_t             cq_wdata;
	cls_t             cq_rdata;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_repeat_q  <= MARK_REPEAT_RST;
			white_repeat_q <= WHITE_REPEAT_RST;
			trip_len_q     <= TRIP_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_MARK_REPEAT:  mark_repeat_q  <= cfg_data[REP_W-1:0];
				REG_WHITE_REPEAT: white_repeat_q <= cfg_data[REP_W-1:0];
				REG_TRIP_LEN:     trip_len_q     <= cfg_data[ARC_W-1:0];
				default: begin
					mark_repeat_q <= mark_repeat_q;
				end
			endcase
		end
	end

	assign rep_cfg.mark_repeat  = mark_repeat_q;
	assign rep_cfg.white_repeat = white_repeat_q;

	lmsq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.poll     (poll),
		.trip_len (trip_len_q),
		.cq_push  (cq_push),
		.cq_data  (cq_wdata),
		.cq_full  (cq_full)
	);

	lmsq_cq u_cq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cq_push),
		.wr_data (cq_wdata),
		.full    (cq_full),
		.rd      (cq_pop),
		.rd_data (cq_rdata),
		.empty   (cq_empty)
	);

	lmsq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rep_cfg  (rep_cfg),
		.cq_data  (cq_rdata),
		.cq_empty (cq_empty),
		.cq_pop   (cq_pop),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* hw/rtl/lmsq_front.sv */
module lmsq_front
	import lmsq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  poll_t            poll,
	input  logic [ARC_W-1:0] trip_len,
	output logic             cq_push,
	output cls_t             cq_data,
	input  logic             cq_full
);

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_now;
	logic advance;

	// classify the incoming poll
	always_comb begin
		cls_now.mode      = mode_t'(poll.req_type);
		cls_now.mark_seen = is_mark(poll.sensor_bits);
		cls_now.any_set   = |poll.sensor_bits;
		cls_now.dist_ok   = poll.distance >= $signed({1'b0, trip_len});
	end

	// stage moves when empty or when the queue takes its item
	assign advance = !valid_s1 || !cq_full;
	assign full    = !advance;
	assign cq_push = valid_s1 && !cq_full;
	assign cq_data = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			cls_s1 <= cls_now;
		end
	end

endmodule

/* hw/rtl/lmsq_cq.sv */
module lmsq_cq
	import lmsq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cls_t wr_data,
	output logic full,
	input  logic rd,
	output cls_t rd_data,
	output logic empty
);

	cls_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hw/rtl/lmsq_back.sv */
module lmsq_back
	import lmsq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rep_cfg_t rep_cfg,
	input  cls_t     cq_data,
	input  logic     cq_empty,
	output logic     cq_pop,
	output logic     empty,
	input  logic     pop,
	output result_t  result
);

	logic [CNT_W-1:0] white_q;
	logic [CNT_W-1:0] mark_q;
	logic [CNT_W-1:0] white_n;
	logic [CNT_W-1:0] mark_n;
	logic [CNT_W-1:0] white_inc;
	logic [CNT_W-1:0] mark_inc;
	logic             done;
	logic             fire;
	result_t          res_now;

	result_t          omem [2];
	logic             owr_ptr_q;
	logic             ord_ptr_q;
	logic [1:0]       ocnt_q;
	logic             ofull;
	logic             do_rd;

	assign ofull  = ocnt_q == 2'd2;
	assign fire   = !cq_empty && !ofull;
	assign cq_pop = fire;

	// saturating increments
	assign white_inc = (white_q == CNT_MAX) ? CNT_MAX : white_q + 1'b1;
	assign mark_inc  = (mark_q == CNT_MAX) ? CNT_MAX : mark_q + 1'b1;

	// counter update per mode
	always_comb begin
		white_n = white_q;
		mark_n  = mark_q;
		done    = 1'b0;
		case (cq_data.mode)
			MODE_BLACK: begin
				if (cq_data.any_set) begin
					white_n = '0;
					done    = 1'b1;
				end
			end
			MODE_WHITE: begin
				if (!cq_data.any_set) begin
					if (white_inc >= rep_cfg.white_repeat && cq_data.dist_ok) begin
						white_n = '0;
						done    = 1'b1;
					end else begin
						white_n = white_inc;
					end
				end else begin
					white_n = '0;
				end
			end
			MODE_MARK: begin
				if (cq_data.mark_seen) begin
					if (mark_inc >= rep_cfg.mark_repeat) begin
						mark_n = '0;
						done   = 1'b1;
					end else begin
						mark_n = mark_inc;
					end
				end else begin
					mark_n = '0;
				end
			end
			default: begin
				done = 1'b0;
			end
		endcase
		res_now.done_res  = done;
		res_now.mark_seen = cq_data.mark_seen;
		res_now.white_run = white_n;
		res_now.mark_run  = mark_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_q <= '0;
			mark_q  <= '0;
		end else if (fire) begin
			white_q <= white_n;
			mark_q  <= mark_n;
		end
	end

	// result queue
	assign empty  = ocnt_q == 2'd0;
	assign do_rd  = pop && !empty;
	assign result = omem[ord_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= 1'b0;
			ord_ptr_q <= 1'b0;
			ocnt_q    <= 2'd0;
		end else begin
			if (fire) begin
				owr_ptr_q <= !owr_ptr_q;
			end
			if (do_rd) begin
				ord_ptr_q <= !ord_ptr_q;
			end
			if (fire && !do_rd) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (do_rd && !fire) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			omem[owr_ptr_q] <= res_now;
		end
	end

	// checks
	a_white_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && done && cq_data.mode == MODE_WHITE |=> white_q == '0)
		else $error("white counter not cleared on finish");

	a_black_keeps_mark: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cq_data.mode == MODE_BLACK |=> $stable(mark_q))
		else $error("black mode changed mark counter");

	a_mark_done_seen: assert property (@(posedge clk) disable iff (!arst_n)
		fire && done && cq_data.mode == MODE_MARK |-> cq_data.mark_seen)
		else $error("mark finish without mark pattern");

	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("result queue count out of range");

endmodule

/* test/line_mark_stop_qualifier_check.sv */
`timescale 1ns / 1ps

module line_mark_stop_qualifier_check
	import lmsq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  poll_t                poll,
	input  logic                 empty,
	input  logic                 pop,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   errors,
	output int                   pending
);

	localparam int PRINT_LIMIT = 40;

	// shadow of the qualifier settings and run counters
	logic [REP_W-1:0] mark_need;
	logic [REP_W-1:0] white_need;
	logic [ARC_W-1:0] arc_min;
	logic [CNT_W-1:0] white_cnt;
	logic [CNT_W-1:0] mark_cnt;

	result_t expected_q[$];
	int      fails;
	int      popped;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fails < PRINT_LIMIT) begin
			$display("mismatch on result %0d: %s got %0d expected %0d", popped, what, got, want);
		end
		fails++;
	endtask

	// one poll: update the counters and form the expected result item
	task automatic qualify_poll(input poll_t p, output result_t r);
		logic seen;
		logic done;
		seen = 1'b0;
		done = 1'b0;
		foreach (MARK_PATTERNS[i]) begin
			if (MARK_PATTERNS[i] == p.sensor_bits) begin
				seen = 1'b1;
			end
		end
		case (mode_t'(p.req_type))
			MODE_BLACK: begin
				if (p.sensor_bits != '0) begin
					white_cnt = '0;
					done = 1'b1;
				end
			end
			MODE_WHITE: begin
				if (p.sensor_bits == '0) begin
					if (white_cnt != CNT_MAX) begin
						white_cnt = white_cnt + 1'b1;
					end
					// distance is signed, so a negative one never reaches the arc
					if (white_cnt >= white_need &&
					    $signed(p.distance) >= $signed({1'b0, arc_min})) begin
						white_cnt = '0;
						done = 1'b1;
					end
				end else begin
					white_cnt = '0;
				end
			end
			MODE_MARK: begin
				if (seen) begin
					if (mark_cnt != CNT_MAX) begin
						mark_cnt = mark_cnt + 1'b1;
					end
					if (mark_cnt >= mark_need) begin
						mark_cnt = '0;
						done = 1'b1;
					end
				end else begin
					mark_cnt = '0;
				end
			end
			default: begin
				// unused mode leaves everything alone
			end
		endcase
		r.done_res  = done;
		r.mark_seen = seen;
		r.white_run = white_cnt;
		r.mark_run  = mark_cnt;
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		if (got.done_res !== want.done_res) begin
			report_mismatch("done_res", got.done_res, want.done_res);
		end
		if (got.mark_seen !== want.mark_seen) begin
			report_mismatch("mark_seen", got.mark_seen, want.mark_seen);
		end
		if (got.white_run !== want.white_run) begin
			report_mismatch("white_run", got.white_run, want.white_run);
		end
		if (got.mark_run !== want.mark_run) begin
			report_mismatch("mark_run", got.mark_run, want.mark_run);
		end
	endtask

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			mark_need  = MARK_REPEAT_RST;
			white_need = WHITE_REPEAT_RST;
			arc_min    = TRIP_LEN_RST;
			white_cnt  = '0;
			mark_cnt   = '0;
			expected_q.delete();
			fails      = 0;
			popped     = 0;
		end else begin
			// result side first: an item accepted now cannot come out at this edge
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", int'(result), 0);
				end else begin
					want = expected_q.pop_front();
					compare_result(result, want);
				end
				popped++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					REG_MARK_REPEAT:  mark_need  = cfg_data[REP_W-1:0];
					REG_WHITE_REPEAT: white_need = cfg_data[REP_W-1:0];
					REG_TRIP_LEN:     arc_min    = cfg_data[ARC_W-1:0];
					default: begin
					end
				endcase
			end
			if (push && !full) begin
				qualify_poll(poll, want);
				expected_q.push_back(want);
			end
		end
		pending <= expected_q.size();
		errors  <= fails;
	end

endmodule

/* test/line_mark_stop_qualifier_test.sv */
`timescale 1ns / 1ps

module line_mark_stop_qualifier_test;
	import lmsq_pkg::*;

	localparam int RUN_LIMIT    = 400000;
	localparam int SETTLE_WAIT  = 8;
	localparam int PAD_W        = CFG_DAT_W - REP_W;
	localparam int DIST_MAX     = 2 ** (DIST_W - 1) - 1;
	localparam int DIST_MIN     = -(2 ** (DIST_W - 1));
	localparam int SAT_RUN      = 270;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	poll_t                poll;
	logic                 empty;
	logic                 pop;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	int errors;
	int pending;
	int cycles = 0;
	bit push_quiet;
	int pop_quiet_left;

	// settings currently in the block, used to shape the polls
	logic [REP_W-1:0] cur_mark;
	logic [REP_W-1:0] cur_white;
	logic [ARC_W-1:0] cur_arc;

	line_mark_stop_qualifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.poll      (poll),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	line_mark_stop_qualifier_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.poll      (poll),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard stop for a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int draw_wait(input bit quiet);
		if (quiet || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// distances cluster around the arc length, plus extremes and negatives
	function automatic logic signed [DIST_W-1:0] pick_distance();
		int d;
		case ($urandom_range(0, 5))
			0: d = int'($urandom);
			1: d = int'(cur_arc) + int'($urandom_range(0, 4)) - 2;
			2: d = ($urandom_range(0, 1) != 0) ? DIST_MAX : DIST_MIN;
			3: d = -int'($urandom_range(1, 524288));
			default: begin
				d = int'(cur_arc) + int'($urandom_range(0, 4096));
				if (d > DIST_MAX) begin
					d = DIST_MAX;
				end
			end
		endcase
		return DIST_W'(d);
	endfunction

	// sensor pattern that advances the given mode
	function automatic logic [SENS_W-1:0] qualifying_bits(input mode_t m);
		case (m)
			MODE_WHITE: return '0;
			MODE_MARK:  return MARK_PATTERNS[$urandom_range(0, NUM_MARKS - 1)];
			default:    return SENS_W'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic send_poll(input mode_t m, input logic [SENS_W-1:0] bits,
	                         input logic signed [DIST_W-1:0] dist_in);
		int     gap;
		poll_t  p;
		gap = draw_wait(push_quiet);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.req_type    = m;
		p.sensor_bits = bits;
		p.distance    = dist_in;
		poll <= p;
		push <= 1'b1;
		do @(posedge clk); while (full !== 1'b0);
	endtask

	// stop sending and let every expected result drain out
	task automatic settle();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
	endtask

	// repeat registers get junk in the unused upper data bits
	task automatic set_config(input logic [REP_W-1:0] mark, input logic [REP_W-1:0] white,
	                          input logic [ARC_W-1:0] arc);
		write_reg(REG_MARK_REPEAT, {PAD_W'($urandom), mark});
		write_reg(REG_WHITE_REPEAT, {PAD_W'($urandom), white});
		write_reg(REG_TRIP_LEN, arc);
		if ($urandom_range(0, 1) != 0) begin
			write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
		end
		cfg_valid <= 1'b0;
		cur_mark  = mark;
		cur_white = white;
		cur_arc   = arc;
	endtask

	// mostly clean runs of one mode, some with a break, plus noise
	task automatic run_phase(input int count);
		int    sent;
		int    len;
		int    need;
		int    brk;
		int    k;
		mode_t m;
		sent = 0;
		while (sent < count) begin
			push_quiet = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				7, 8: begin
					m = mode_t'($urandom_range(0, 3));
					send_poll(m, SENS_W'($urandom), DIST_W'($urandom));
					if (m != MODE_NONE) begin
						sent++;
					end
				end
				9: begin
					send_poll(MODE_NONE, qualifying_bits(MODE_MARK), pick_distance());
				end
				default: begin
					m = mode_t'($urandom_range(0, 2));
					need = (m == MODE_MARK) ? int'(cur_mark) :
					       (m == MODE_WHITE) ? int'(cur_white) : 1;
					if ($urandom_range(0, 1) != 0) begin
						len = need + $urandom_range(0, 3);
					end else begin
						len = $urandom_range(1, need + 3);
					end
					if (len == 0) begin
						len = 1;
					end
					brk = ($urandom_range(0, 9) < 7) ? -1 : $urandom_range(0, len - 1);
					for (k = 0; k < len; k++) begin
						if (k == brk) begin
							send_poll(m, SENS_W'($urandom), pick_distance());
						end else begin
							send_poll(m, qualifying_bits(m), pick_distance());
						end
					end
					sent += len;
				end
			endcase
		end
	endtask

	// result side: random stalls with occasional stretches of steady pops
	initial begin
		int gap;
		pop <= 1'b0;
		pop_quiet_left = 0;
		forever begin
			if (pop_quiet_left > 0) begin
				pop_quiet_left--;
			end else if ($urandom_range(0, 29) == 0) begin
				pop_quiet_left = $urandom_range(10, 60);
			end
			gap = draw_wait(pop_quiet_left > 0);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
		end
	end

	initial begin
		int k;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		poll      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MARK_REPEAT;
		cfg_data  <= '0;
		cur_mark   = MARK_REPEAT_RST;
		cur_white  = WHITE_REPEAT_RST;
		cur_arc    = TRIP_LEN_RST;
		push_quiet = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed polls on reset settings: black, white around the arc, all marks
		send_poll(MODE_BLACK, 8'h00, 20'sd0);
		send_poll(MODE_BLACK, 8'h80, 20'sd0);
		send_poll(MODE_WHITE, 8'h00, DIST_W'(DIST_MIN));
		send_poll(MODE_WHITE, 8'h00, 20'sd1919);
		send_poll(MODE_WHITE, 8'h00, 20'sd1920);
		send_poll(MODE_WHITE, 8'h01, 20'sd1920);
		send_poll(MODE_WHITE, 8'h00, DIST_W'(DIST_MAX));
		send_poll(MODE_WHITE, 8'h00, DIST_W'(DIST_MAX));
		send_poll(MODE_WHITE, 8'h00, 20'sd0);
		for (k = 0; k < NUM_MARKS; k++) begin
			send_poll(MODE_MARK, MARK_PATTERNS[k], pick_distance());
		end
		send_poll(MODE_MARK, 8'h0F, 20'sd0);
		send_poll(MODE_MARK, 8'hBF, 20'sd0);
		send_poll(MODE_MARK, 8'hF0, 20'sd0);
		send_poll(MODE_NONE, 8'hFF, -20'sd1);
		send_poll(MODE_BLACK, 8'h1F, 20'sd0);
		send_poll(MODE_WHITE, 8'h00, 20'sd1920);

		// low extreme settings
		settle();
		set_config(8'd1, 8'd1, '0);
		run_phase(150);

		// high extreme settings, long mark runs
		settle();
		set_config(8'd255, 8'd255, {ARC_W{1'b1}});
		run_phase(300);

		// repeat of zero finishes on the first qualifying poll
		settle();
		set_config(8'd0, 8'd0, ARC_W'($urandom));
		run_phase(150);

		for (k = 0; k < 4; k++) begin
			settle();
			if (k == 3) begin
				set_config(REP_W'($urandom_range(1, 40)), REP_W'($urandom_range(1, 40)),
				           ARC_W'($urandom));
			end else begin
				set_config(REP_W'($urandom_range(1, 8)), REP_W'($urandom_range(1, 8)),
				           ARC_W'($urandom));
			end
			run_phase(180);
		end

		// white counter runs into its ceiling, then finishes there
		settle();
		set_config(REP_W'($urandom_range(1, 8)), 8'd255, 19'd600);
		push_quiet = 1'b0;
		for (k = 0; k < SAT_RUN; k++) begin
			send_poll(MODE_WHITE, 8'h00, DIST_W'(-int'($urandom_range(1, 524288))));
		end
		send_poll(MODE_WHITE, 8'h00, 20'sd600);

		settle();
		if (errors == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* line_mark_stop_qualifier.f */
hw/rtl/lmsq_pkg.sv
hw/rtl/lmsq_front.sv
hw/rtl/lmsq_cq.sv
hw/rtl/lmsq_back.sv
hw/rtl/line_mark_stop_qualifier.sv
test/line_mark_stop_qualifier_check.sv
test/line_mark_stop_qualifier_test.sv
